### sv/ecam_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the fly-camera block: channel payloads,
// sequencer states, serial unit commands and the CORDIC arctangent table.
package ecam_pkg;

   // Input item of the request channel.
   typedef struct packed {
      logic               func;
      logic signed [15:0] mouse_dx;
      logic signed [15:0] mouse_dy;
      logic        [15:0] tick_seconds;
      logic               key_forward;
      logic               key_back;
      logic               key_left;
      logic               key_right;
      logic               key_rise;
      logic               key_sink;
   } req_type;

   // Result item of the response channel.
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
   } rsp_type;

   // Configuration register indexes.
   localparam int CSR_IW = 3;
   typedef enum logic [CSR_IW-1:0] {
      CSR_MOUSE_ENABLE = 3'd0,
      CSR_MOUSE_GAIN   = 3'd1,
      CSR_UP_X         = 3'd2,
      CSR_UP_Y         = 3'd3,
      CSR_UP_Z         = 3'd4
   } csr_idx_type;

   // Item kinds.
   localparam logic FUNC_MOUSE = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // Sequencer states of the top level.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MGAIN,
      ST_CORDIC,
      ST_DIRMUL,
      ST_CROSS,
      ST_SQUARE,
      ST_SQRT,
      ST_DIV,
      ST_MOVE,
      ST_DONE
   } st_type;

   // Operations of the bit-serial arithmetic unit.
   typedef enum logic [1:0] {
      SER_MUL,
      SER_SQRT,
      SER_DIV
   } ser_op_type;

   localparam int SER_AW = 64;
   localparam int SER_BW = 32;
   localparam int DIV_QW = 15;

   typedef struct packed {
      logic                start;
      ser_op_type          op;
      logic [SER_AW-1:0]   opa;
      logic [SER_BW-1:0]   opb;
   } ser_cmd_type;

   // CORDIC datapath widths and constants (angles in degrees * 2^16).
   localparam int CORDIC_W = 34;
   localparam int ANG_W    = 32;
   localparam int ATAN_W   = 22;
   localparam int ATAN_IW  = 5;
   localparam logic signed [CORDIC_W-1:0] INV_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [ANG_W-1:0]    QUARTER_TURN = 32'sd5898240;
   localparam logic signed [ANG_W-1:0]    HALF_TURN    = 32'sd11796480;

   // Angle limits in Q8 degrees.
   localparam logic signed [18:0] YAW_HALF    = 19'sd46080;
   localparam logic signed [18:0] YAW_FULL    = 19'sd92160;
   localparam logic signed [18:0] PITCH_LIMIT = 19'sd22784;
   localparam logic signed [16:0] YAW_RESET   = -17'sd23040;

   // Unit length in Q2.14.
   localparam logic [DIV_QW-1:0]  DIR_ONE     = 15'd16384;

   // Arctangent of 2^-i in degrees * 2^16, rounded to nearest.
   function automatic logic [ATAN_W-1:0] atan_deg16(input logic [ATAN_IW-1:0] i);
      logic [ATAN_W-1:0] r;
      unique case (i)
         5'd0:    r = 22'd2949120;
         5'd1:    r = 22'd1740967;
         5'd2:    r = 22'd919879;
         5'd3:    r = 22'd466945;
         5'd4:    r = 22'd234379;
         5'd5:    r = 22'd117304;
         5'd6:    r = 22'd58666;
         5'd7:    r = 22'd29335;
         5'd8:    r = 22'd14668;
         5'd9:    r = 22'd7334;
         5'd10:   r = 22'd3667;
         5'd11:   r = 22'd1833;
         5'd12:   r = 22'd917;
         5'd13:   r = 22'd458;
         5'd14:   r = 22'd229;
         5'd15:   r = 22'd115;
         5'd16:   r = 22'd57;
         5'd17:   r = 22'd29;
         5'd18:   r = 22'd14;
         5'd19:   r = 22'd7;
         5'd20:   r = 22'd4;
         5'd21:   r = 22'd2;
         5'd22:   r = 22'd1;
         default: r = 22'd0;
      endcase
      return r;
   endfunction

   // Magnitude of a signed datapath word.
   function automatic logic [CORDIC_W-1:0] mag34(input logic signed [CORDIC_W-1:0] v);
      return v[CORDIC_W-1] ? CORDIC_W'(-v) : CORDIC_W'(v);
   endfunction

endpackage

### sv/ecam_serial.sv
`timescale 1ns / 1ps
// Bit-serial arithmetic unit: shift-add multiply, bit-pair square root and
// restoring division, one bit per cycle. Depends on ecam_pkg.
module ecam_serial (
   input  logic                     clock,
   input  logic                     reset,
   input  ecam_pkg::ser_cmd_type    cmd,
   output logic                     done,
   output logic [ecam_pkg::SER_AW-1:0] result
);
   import ecam_pkg::*;

   logic              busy_ff, busy_in;
   ser_op_type        op_ff, op_in;
   logic [SER_AW-1:0] a_ff, a_in;
   logic [SER_AW-1:0] b_ff, b_in;
   logic [SER_AW-1:0] c_ff, c_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic              fin;
   logic [SER_AW-1:0] trial;
   logic              ge;

   // Finish condition per operation: multiplier bits used up, root bit
   // shifted out, or all quotient bits produced.
   always_comb begin
      unique case (op_ff)
         SER_MUL:  fin = (b_ff == '0);
         SER_SQRT: fin = (b_ff == '0);
         SER_DIV:  fin = (cnt_ff == '0);
         default:  fin = 1'b1;
      endcase
   end

   assign done = busy_ff && fin;

   always_comb begin
      unique case (op_ff)
         SER_DIV: result = SER_AW'(a_ff[DIV_QW-1:0]);
         default: result = c_ff;
      endcase
   end

   // One step of the selected operation.
   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      c_in    = c_ff;
      cnt_in  = cnt_ff;
      trial   = '0;
      ge      = 1'b0;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         unique case (cmd.op)
            SER_MUL: begin
               a_in = cmd.opa;
               b_in = SER_AW'(cmd.opb);
               c_in = '0;
            end
            SER_SQRT: begin
               a_in = cmd.opa;
               b_in = SER_AW'(1) << (SER_AW - 2);
               c_in = '0;
            end
            SER_DIV: begin
               a_in   = cmd.opa;
               b_in   = SER_AW'(cmd.opb);
               c_in   = cmd.opa >> DIV_QW;
               cnt_in = 4'(DIV_QW);
            end
            default: ;
         endcase
      end else if (busy_ff) begin
         if (fin) begin
            busy_in = 1'b0;
         end else begin
            unique case (op_ff)
               SER_MUL: begin
                  if (b_ff[0]) begin
                     c_in = c_ff + a_ff;
                  end
                  a_in = a_ff << 1;
                  b_in = b_ff >> 1;
               end
               SER_SQRT: begin
                  trial = c_ff + b_ff;
                  if (a_ff >= trial) begin
                     a_in = a_ff - trial;
                     c_in = (c_ff >> 1) + b_ff;
                  end else begin
                     c_in = c_ff >> 1;
                  end
                  b_in = b_ff >> 2;
               end
               SER_DIV: begin
                  trial = {c_ff[SER_AW-2:0], a_ff[DIV_QW-1]};
                  ge    = (trial >= b_ff);
                  c_in  = ge ? trial - b_ff : trial;
                  a_in  = {a_ff[SER_AW-1:DIV_QW], a_ff[DIV_QW-2:0], ge};
                  cnt_in = cnt_ff - 4'd1;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         op_ff   <= SER_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
   end

   // A new command never lands on an operation still in flight.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("serial unit started while busy");

   // The divider is only used where the quotient stays within one unit.
   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (done && op_ff == SER_DIV) |-> (a_ff[DIV_QW-1:0] <= DIR_ONE))
      else $error("normalizing quotient above one");

endmodule

### sv/ecam_cordic.sv
`timescale 1ns / 1ps
// Iterative rotation-mode CORDIC: sine and cosine in Q30 of a Q8 degree
// angle, one micro-rotation per cycle. Depends on ecam_pkg.
module ecam_cordic #(
   parameter int STEPS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [16:0]                  ang,
   output logic                                done,
   output logic signed [ecam_pkg::CORDIC_W-1:0] cos_out,
   output logic signed [ecam_pkg::CORDIC_W-1:0] sin_out
);
   import ecam_pkg::*;

   localparam int CW = $clog2(STEPS + 1);

   logic                       busy_ff, busy_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [ANG_W-1:0]    z_ff, z_in, z0, at;
   logic                       neg_ff, neg_in;

   assign done    = busy_ff && (cnt_ff == CW'(STEPS));
   assign cos_out = neg_ff ? -x_ff : x_ff;
   assign sin_out = neg_ff ? -y_ff : y_ff;

   // Fold the angle into +-90 degrees, then rotate toward zero residual.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      neg_in  = neg_ff;
      z0      = ANG_W'(ang) <<< 8;
      xs      = x_ff >>> cnt_ff;
      ys      = y_ff >>> cnt_ff;
      at      = ANG_W'(atan_deg16(ATAN_IW'(cnt_ff)));
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = INV_GAIN_Q30;
         y_in    = '0;
         if (z0 > QUARTER_TURN) begin
            z_in   = z0 - HALF_TURN;
            neg_in = 1'b1;
         end else if (z0 < -QUARTER_TURN) begin
            z_in   = z0 + HALF_TURN;
            neg_in = 1'b1;
         end else begin
            z_in   = z0;
            neg_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (done) begin
            busy_in = 1'b0;
         end else begin
            if (!z_ff[ANG_W-1]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + at;
            end
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
   end

   // A rotation is never restarted halfway.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("CORDIC started while busy");

endmodule

### sv/euler_fly_camera_update.sv
`timescale 1ns / 1ps
// Free-fly camera block. Channels: req_* takes one item per beat (mouse
// movement or keyboard tick), rsp_* returns one beat per item holding the
// position and look direction after that item, csr_* writes the mouse
// enable, mouse gain and world up vector (always ready, one write a cycle).
// One item is worked at a time by a sequencer over a shared bit-serial
// arithmetic unit (multiply, square root, divide, one bit per cycle) and an
// iterative CORDIC (one micro-rotation per cycle). A mouse item runs two
// gain products, two CORDIC runs, two direction products, three squares, a
// square root and three divides, or none of these when mouse input is
// disabled. A tick item works the cross product, its normalization and up
// to eighteen step products.
// Multiply time follows the magnitude of the multiplier operand.
// Reset is synchronous: position zero, yaw -90 degrees, pitch zero, look
// (0, 0, -1), registers at their defaults. The result sits in an output
// register; while the receiver stalls the next item is already accepted and
// worked, and it waits in the sequencer until the output register frees.
// Depends on ecam_pkg, ecam_serial and ecam_cordic.
module euler_fly_camera_update #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ecam_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ecam_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ecam_pkg::CSR_IW-1:0]   csr_index,
   input  logic [15:0]                   csr_data
);
   import ecam_pkg::*;

   localparam logic signed [34:0] POS_MAX = 35'sd2147483647;
   localparam logic signed [34:0] POS_MIN = -35'sd2147483648;

   // Sequencer and handshake state.
   st_type            state_ff, state_in;
   logic [2:0]        k_ff, k_in;
   logic [1:0]        ax_ff, ax_in;
   logic              wait_ff, wait_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   req_type           item_ff, item_in;

   // Configuration.
   logic              en_ff;
   logic [15:0]       gain_ff;
   logic signed [15:0] upv_ff [3];

   // Camera state.
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];
   logic signed [16:0] yaw_ff, yaw_in;
   logic signed [15:0] pitch_ff, pitch_in;
   logic signed [15:0] look_ff [3];
   logic signed [15:0] look_in [3];

   // Working registers.
   logic signed [CORDIC_W-1:0] cy_ff, cy_in, sy_ff, sy_in, cp_ff, cp_in;
   logic signed [CORDIC_W-1:0] vec_ff [3];
   logic signed [CORDIC_W-1:0] vec_in [3];
   logic [SER_AW-1:0]  sum_ff, sum_in;
   logic [SER_BW-1:0]  root_ff, root_in;
   logic signed [15:0] side_ff [3];
   logic signed [15:0] side_in [3];
   logic               has_side_ff, has_side_in;
   logic               mneg_ff, mneg_in;

   // Unit connections.
   ser_cmd_type        ser_cmd;
   logic               ser_done;
   logic [SER_AW-1:0]  ser_res;
   logic               cor_start;
   logic signed [16:0] cor_ang;
   logic               cor_done;
   logic signed [CORDIC_W-1:0] cor_cos, cor_sin;

   // Combinational helpers.
   logic signed [64:0]  prod;
   logic [1:0]          vsel;
   logic signed [CORDIC_W-1:0] vcur, la, ub, mv;
   logic signed [17:0]  dang;
   logic signed [18:0]  yw, pt;
   logic [18:0]         dt7;
   logic [5:0]          keys;
   logic                key_on, plus;
   logic signed [CORDIC_W-1:0] step;
   logic signed [34:0]  psum;
   logic [DIV_QW-1:0]   q;
   logic signed [15:0]  nrm;

   ecam_serial u_serial (
      .clock  (clock),
      .reset  (reset),
      .cmd    (ser_cmd),
      .done   (ser_done),
      .result (ser_res)
   );

   ecam_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .ang     (cor_ang),
      .done    (cor_done),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Signed view of the last product.
   assign prod = mneg_ff ? -$signed({1'b0, ser_res}) : $signed({1'b0, ser_res});

   assign dt7  = {item_ff.tick_seconds, 3'b000} - 19'(item_ff.tick_seconds);
   assign keys = {item_ff.key_sink, item_ff.key_rise, item_ff.key_right,
                  item_ff.key_left, item_ff.key_back, item_ff.key_forward};
   assign vsel = (state_ff == ST_CROSS) ? k_ff[2:1] : k_ff[1:0];
   assign vcur = vec_ff[vsel];

   // Sequencer: next state, unit commands and datapath updates.
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      ax_in        = ax_ff;
      wait_in      = wait_ff;
      item_in      = item_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pos_in       = pos_ff;
      yaw_in       = yaw_ff;
      pitch_in     = pitch_ff;
      look_in      = look_ff;
      cy_in        = cy_ff;
      sy_in        = sy_ff;
      cp_in        = cp_ff;
      vec_in       = vec_ff;
      sum_in       = sum_ff;
      root_in      = root_ff;
      side_in      = side_ff;
      has_side_in  = has_side_ff;
      mneg_in      = mneg_ff;
      req_ready    = 1'b0;
      ser_cmd      = '{start: 1'b0, op: SER_MUL, opa: '0, opb: '0};
      cor_start    = 1'b0;
      cor_ang      = yaw_ff;
      la           = '0;
      ub           = '0;
      mv           = '0;
      dang         = 18'((prod + 65'sd32768) >>> 16);
      yw           = '0;
      pt           = '0;
      key_on       = keys[k_ff] && ((k_ff < 3'd2) || (k_ff > 3'd3) || has_side_ff);
      plus         = (k_ff == 3'd0) || (k_ff == 3'd3) || (k_ff == 3'd4);
      step         = CORDIC_W'((prod + 65'sd16384) >>> 15);
      psum         = '0;
      q            = (ser_res[DIV_QW-1:0] > DIR_ONE) ? DIR_ONE : ser_res[DIV_QW-1:0];
      nrm          = vcur[CORDIC_W-1] ? -16'(q) : 16'(q);

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in = req_data;
               k_in    = '0;
               ax_in   = '0;
               wait_in = 1'b0;
               if (req_data.func == FUNC_TICK) begin
                  state_in = ST_CROSS;
               end else if (en_ff) begin
                  state_in = ST_MGAIN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         // Scale the mouse offsets by the gain and update yaw and pitch.
         ST_MGAIN: begin
            mv = (k_ff == 3'd0) ? CORDIC_W'(item_ff.mouse_dx) : CORDIC_W'(item_ff.mouse_dy);
            if (!wait_ff) begin
               ser_cmd = '{start: 1'b1, op: SER_MUL,
                           opa: SER_AW'(mag34(mv)), opb: SER_BW'(gain_ff)};
               mneg_in = mv[CORDIC_W-1];
               wait_in = 1'b1;
            end else if (ser_done) begin
               wait_in = 1'b0;
               if (k_ff == 3'd0) begin
                  yw = 19'(yaw_ff) + 19'(dang);
                  if (yw >= YAW_HALF) begin
                     yw = yw - YAW_FULL;
                  end else if (yw < -YAW_HALF) begin
                     yw = yw + YAW_FULL;
                  end
                  yaw_in = yw[16:0];
                  k_in   = 3'd1;
               end else begin
                  pt = 19'(pitch_ff) + 19'(dang);
                  if (pt > PITCH_LIMIT) begin
                     pt = PITCH_LIMIT;
                  end else if (pt < -PITCH_LIMIT) begin
                     pt = -PITCH_LIMIT;
                  end
                  pitch_in = pt[15:0];
                  k_in     = '0;
                  state_in = ST_CORDIC;
               end
            end
         end

         // Sine and cosine of yaw, then of pitch.
         ST_CORDIC: begin
            cor_ang = (k_ff == 3'd0) ? yaw_ff : 17'(pitch_ff);
            if (!wait_ff) begin
               cor_start = 1'b1;
               wait_in   = 1'b1;
            end else if (cor_done) begin
               wait_in = 1'b0;
               if (k_ff == 3'd0) begin
                  cy_in = cor_cos;
                  sy_in = cor_sin;
                  k_in  = 3'd1;
               end else begin
                  cp_in     = cor_cos;
                  vec_in[1] = cor_sin;
                  k_in      = '0;
                  state_in  = ST_DIRMUL;
               end
            end
         end

         // Horizontal components scaled by the cosine of pitch.
         ST_DIRMUL: begin
            mv = (k_ff == 3'd0) ? cy_ff : sy_ff;
            if (!wait_ff) begin
               ser_cmd = '{start: 1'b1, op: SER_MUL,
                           opa: SER_AW'(mag34(mv)), opb: SER_BW'(mag34(cp_ff))};
               mneg_in = mv[CORDIC_W-1] ^ cp_ff[CORDIC_W-1];
               wait_in = 1'b1;
            end else if (ser_done) begin
               wait_in = 1'b0;
               if (k_ff == 3'd0) begin
                  vec_in[0] = CORDIC_W'(prod >>> 30);
                  k_in      = 3'd1;
               end else begin
                  vec_in[2] = CORDIC_W'(prod >>> 30);
                  k_in      = '0;
                  sum_in    = '0;
                  state_in  = ST_SQUARE;
               end
            end
         end

         // Cross product of look and up, one partial product per pass.
         ST_CROSS: begin
            unique case (k_ff)
               3'd0: begin la = CORDIC_W'(look_ff[1]); ub = CORDIC_W'(upv_ff[2]); end
               3'd1: begin la = CORDIC_W'(look_ff[2]); ub = CORDIC_W'(upv_ff[1]); end
               3'd2: begin la = CORDIC_W'(look_ff[2]); ub = CORDIC_W'(upv_ff[0]); end
               3'd3: begin la = CORDIC_W'(look_ff[0]); ub = CORDIC_W'(upv_ff[2]); end
               3'd4: begin la = CORDIC_W'(look_ff[0]); ub = CORDIC_W'(upv_ff[1]); end
               3'd5: begin la = CORDIC_W'(look_ff[1]); ub = CORDIC_W'(upv_ff[0]); end
               default: begin la = '0; ub = '0; end
            endcase
            if (!wait_ff) begin
               ser_cmd = '{start: 1'b1, op: SER_MUL,
                           opa: SER_AW'(mag34(la)), opb: SER_BW'(mag34(ub))};
               mneg_in = la[CORDIC_W-1] ^ ub[CORDIC_W-1];
               wait_in = 1'b1;
            end else if (ser_done) begin
               wait_in      = 1'b0;
               vec_in[vsel] = k_ff[0] ? vcur - CORDIC_W'(prod) : CORDIC_W'(prod);
               if (k_ff == 3'd5) begin
                  k_in     = '0;
                  sum_in   = '0;
                  state_in = ST_SQUARE;
               end else begin
                  k_in = k_ff + 3'd1;
               end
            end
         end

         // Sum of squares of the vector to normalize.
         ST_SQUARE: begin
            if (!wait_ff) begin
               ser_cmd = '{start: 1'b1, op: SER_MUL,
                           opa: SER_AW'(mag34(vcur)), opb: SER_BW'(mag34(vcur))};
               mneg_in = 1'b0;
               wait_in = 1'b1;
            end else if (ser_done) begin
               wait_in = 1'b0;
               sum_in  = sum_ff + ser_res;
               if (k_ff == 3'd2) begin
                  k_in = '0;
                  if (item_ff.func == FUNC_TICK) begin
                     has_side_in = (sum_in != '0);
                  end
                  if (sum_in != '0) begin
                     state_in = ST_SQRT;
                  end else if (item_ff.func == FUNC_TICK) begin
                     ax_in    = '0;
                     state_in = ST_MOVE;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else begin
                  k_in = k_ff + 3'd1;
               end
            end
         end

         // Length of the vector.
         ST_SQRT: begin
            if (!wait_ff) begin
               ser_cmd = '{start: 1'b1, op: SER_SQRT, opa: sum_ff, opb: '0};
               wait_in = 1'b1;
            end else if (ser_done) begin
               wait_in  = 1'b0;
               root_in  = ser_res[SER_BW-1:0];
               k_in     = '0;
               state_in = ST_DIV;
            end
         end

         // Each component scaled to Q2.14, rounded half away from zero.
         ST_DIV: begin
            if (!wait_ff) begin
               ser_cmd = '{start: 1'b1, op: SER_DIV,
                           opa: SER_AW'({mag34(vcur), 14'b0}) + SER_AW'(root_ff >> 1),
                           opb: root_ff};
               wait_in = 1'b1;
            end else if (ser_done) begin
               wait_in = 1'b0;
               if (item_ff.func == FUNC_TICK) begin
                  side_in[vsel] = nrm;
               end else begin
                  look_in[vsel] = nrm;
               end
               if (k_ff == 3'd2) begin
                  k_in  = '0;
                  ax_in = '0;
                  state_in = (item_ff.func == FUNC_TICK) ? ST_MOVE : ST_DONE;
               end else begin
                  k_in = k_ff + 3'd1;
               end
            end
         end

         // Keys in order forward, back, left, right, rise, sink; one axis
         // per product, each add saturating.
         ST_MOVE: begin
            if (k_ff < 3'd2) begin
               mv = CORDIC_W'(look_ff[ax_ff]);
            end else if (k_ff < 3'd4) begin
               mv = CORDIC_W'(side_ff[ax_ff]);
            end else begin
               mv = CORDIC_W'(upv_ff[ax_ff]);
            end
            if (!key_on) begin
               ax_in = '0;
               if (k_ff == 3'd5) begin
                  state_in = ST_DONE;
               end else begin
                  k_in = k_ff + 3'd1;
               end
            end else if (!wait_ff) begin
               ser_cmd = '{start: 1'b1, op: SER_MUL,
                           opa: SER_AW'(dt7), opb: SER_BW'(mag34(mv))};
               mneg_in = mv[CORDIC_W-1];
               wait_in = 1'b1;
            end else if (ser_done) begin
               wait_in = 1'b0;
               psum = 35'(pos_ff[ax_ff]) + (plus ? 35'(step) : -35'(step));
               if (psum > POS_MAX) begin
                  psum = POS_MAX;
               end else if (psum < POS_MIN) begin
                  psum = POS_MIN;
               end
               pos_in[ax_ff] = psum[31:0];
               if (ax_ff == 2'd2) begin
                  ax_in = '0;
                  if (k_ff == 3'd5) begin
                     state_in = ST_DONE;
                  end else begin
                     k_in = k_ff + 3'd1;
                  end
               end else begin
                  ax_in = ax_ff + 2'd1;
               end
            end
         end

         // Hand the state to the output register once it is free.
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{pos_x: pos_ff[0], pos_y: pos_ff[1], pos_z: pos_ff[2],
                          dir_x: look_ff[0], dir_y: look_ff[1], dir_z: look_ff[2]};
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control, configuration and camera state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         ax_ff        <= '0;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         en_ff        <= 1'b1;
         gain_ff      <= 16'd6554;
         upv_ff[0]    <= '0;
         upv_ff[1]    <= 16'sd16384;
         upv_ff[2]    <= '0;
         pos_ff[0]    <= '0;
         pos_ff[1]    <= '0;
         pos_ff[2]    <= '0;
         yaw_ff       <= YAW_RESET;
         pitch_ff     <= '0;
         look_ff[0]   <= '0;
         look_ff[1]   <= '0;
         look_ff[2]   <= -16'sd16384;
         has_side_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         ax_ff        <= ax_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
         look_ff      <= look_in;
         has_side_ff  <= has_side_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MOUSE_ENABLE: en_ff     <= csr_data[0];
               CSR_MOUSE_GAIN:   gain_ff   <= csr_data;
               CSR_UP_X:         upv_ff[0] <= $signed(csr_data);
               CSR_UP_Y:         upv_ff[1] <= $signed(csr_data);
               CSR_UP_Z:         upv_ff[2] <= $signed(csr_data);
               default: ;
            endcase
         end
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
      cy_ff   <= cy_in;
      sy_ff   <= sy_in;
      cp_ff   <= cp_in;
      vec_ff  <= vec_in;
      sum_ff  <= sum_in;
      root_ff <= root_in;
      side_ff <= side_in;
      mneg_ff <= mneg_in;
   end

   // Pitch stays inside the clamp.
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      (19'(pitch_ff) <= PITCH_LIMIT) && (19'(pitch_ff) >= -PITCH_LIMIT))
      else $error("pitch outside clamp");

   // Yaw stays inside one turn.
   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      (19'(yaw_ff) < YAW_HALF) && (19'(yaw_ff) >= -YAW_HALF))
      else $error("yaw outside one turn");

   // An accepted beat closes the input until its result is handed over.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item accepted while one is in flight");

endmodule

### verif/ecam_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the fly-camera block: watches the request, response and
// register write channels, predicts each response beat and compares it.
// Depends on ecam_pkg for the channel payload types and register indexes.
module ecam_checker #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  ecam_pkg::req_type             req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  ecam_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [ecam_pkg::CSR_IW-1:0]   csr_index,
   input  logic [15:0]                   csr_data,
   output int                            fail_count,
   output int                            pending
);
   import ecam_pkg::*;

   localparam longint ONE_OVER_K  = 652032874;
   localparam longint QUARTER_DEG = 90 * 65536;
   localparam longint HALF_DEG    = 180 * 65536;

   // Arctangent of 2^-i in degrees * 2^16.
   localparam longint ARCTAN [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

   // Camera state and register copy kept by the predictor.
   bit     cam_mouse_on;
   longint cam_gain;
   int     cam_up [3];
   int     cam_pos [3];
   int     cam_yaw;
   int     cam_pitch;
   int     cam_look [3];

   rsp_type camera_after [$];

   assign pending = camera_after.size();

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Scales a vector to unit length in Q2.14; returns 0 for a zero vector.
   function automatic bit to_unit(input longint v [3], output int u [3]);
      longint unsigned sum, len, mag, q;
      sum = 0;
      foreach (v[i]) begin
         mag = v[i] < 0 ? -v[i] : v[i];
         sum += mag * mag;
      end
      if (sum == 0) return 0;
      len = int_sqrt(sum);
      foreach (v[i]) begin
         mag = v[i] < 0 ? -v[i] : v[i];
         q = (mag * 16384 + len / 2) / len;
         if (q > 16384) q = 16384;
         u[i] = v[i] < 0 ? -int'(q) : int'(q);
      end
      return 1;
   endfunction

   // Rotation-mode CORDIC on an angle in Q8 degrees, outputs in Q30.
   function automatic void rotate_angle(input int ang, output longint c, output longint s);
      longint z, x, y, xs, ys;
      bit flip;
      z = longint'(ang) * 256;
      x = ONE_OVER_K;
      y = 0;
      flip = 0;
      if (z > QUARTER_DEG) begin
         z -= HALF_DEG;
         flip = 1;
      end else if (z < -QUARTER_DEG) begin
         z += HALF_DEG;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys;
            y += xs;
            z -= ARCTAN[i];
         end else begin
            x += ys;
            y -= xs;
            z += ARCTAN[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // Moves the position along a Q2.14 axis for dt seconds, saturating.
   function automatic void step_along(input int axis [3], input longint dt, input bit back);
      longint stride, p;
      for (int i = 0; i < 3; i++) begin
         stride = (longint'(axis[i]) * dt * 7 + 16384) >>> 15;
         p = longint'(cam_pos[i]) + (back ? -stride : stride);
         if (p > 64'sd2147483647) p = 64'sd2147483647;
         if (p < -64'sd2147483648) p = -64'sd2147483648;
         cam_pos[i] = int'(p);
      end
   endfunction

   // Applies one request beat to the camera state and returns the new state.
   function automatic rsp_type camera_step(input req_type rq);
      longint yw, pt, cy, sy, cp, sp, dt;
      longint d [3];
      longint cr [3];
      int n [3];
      int side [3];
      bit has_side;
      rsp_type r;
      if (rq.func == FUNC_MOUSE) begin
         if (cam_mouse_on) begin
            yw = cam_yaw + ((longint'(rq.mouse_dx) * cam_gain + 32768) >>> 16);
            pt = cam_pitch + ((longint'(rq.mouse_dy) * cam_gain + 32768) >>> 16);
            if (yw >= 46080) yw -= 92160;
            else if (yw < -46080) yw += 92160;
            if (pt > 22784) pt = 22784;
            if (pt < -22784) pt = -22784;
            cam_yaw = int'(yw);
            cam_pitch = int'(pt);
            rotate_angle(cam_yaw, cy, sy);
            rotate_angle(cam_pitch, cp, sp);
            d[0] = (cy * cp) >>> 30;
            d[1] = sp;
            d[2] = (sy * cp) >>> 30;
            if (to_unit(d, n)) cam_look = n;
         end
      end else begin
         dt = longint'(rq.tick_seconds);
         cr[0] = longint'(cam_look[1]) * cam_up[2] - longint'(cam_look[2]) * cam_up[1];
         cr[1] = longint'(cam_look[2]) * cam_up[0] - longint'(cam_look[0]) * cam_up[2];
         cr[2] = longint'(cam_look[0]) * cam_up[1] - longint'(cam_look[1]) * cam_up[0];
         has_side = to_unit(cr, side);
         if (rq.key_forward) step_along(cam_look, dt, 0);
         if (rq.key_back) step_along(cam_look, dt, 1);
         if (rq.key_left && has_side) step_along(side, dt, 1);
         if (rq.key_right && has_side) step_along(side, dt, 0);
         if (rq.key_rise) step_along(cam_up, dt, 0);
         if (rq.key_sink) step_along(cam_up, dt, 1);
      end
      r.pos_x = cam_pos[0];
      r.pos_y = cam_pos[1];
      r.pos_z = cam_pos[2];
      r.dir_x = 16'(cam_look[0]);
      r.dir_y = 16'(cam_look[1]);
      r.dir_z = 16'(cam_look[2]);
      return r;
   endfunction

   task automatic report(input string field, input longint got, input longint want);
      $display("[%0t] mismatch on %s: got %0d, want %0d", $time, field, got, want);
      fail_count++;
   endtask

   // All three channels are sampled at the clock edge, before any update.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count = 0;
         cam_mouse_on = 1;
         cam_gain = 6554;
         cam_up = '{0, 16384, 0};
         cam_pos = '{0, 0, 0};
         cam_yaw = -23040;
         cam_pitch = 0;
         cam_look = '{0, 0, -16384};
         camera_after.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_idx_type'(csr_index))
               CSR_MOUSE_ENABLE: cam_mouse_on = csr_data[0];
               CSR_MOUSE_GAIN:   cam_gain = longint'(csr_data);
               CSR_UP_X:         cam_up[0] = int'(signed'(csr_data));
               CSR_UP_Y:         cam_up[1] = int'(signed'(csr_data));
               CSR_UP_Z:         cam_up[2] = int'(signed'(csr_data));
               default: ;
            endcase
         end
         if (req_valid && req_ready) camera_after.push_back(camera_step(req_data));
         if (rsp_valid && rsp_ready) begin
            if (camera_after.size() == 0) begin
               $display("[%0t] response beat with nothing outstanding", $time);
               fail_count++;
            end else begin
               want = camera_after.pop_front();
               if (rsp_data.pos_x !== want.pos_x) report("pos_x", rsp_data.pos_x, want.pos_x);
               if (rsp_data.pos_y !== want.pos_y) report("pos_y", rsp_data.pos_y, want.pos_y);
               if (rsp_data.pos_z !== want.pos_z) report("pos_z", rsp_data.pos_z, want.pos_z);
               if (rsp_data.dir_x !== want.dir_x) report("dir_x", rsp_data.dir_x, want.dir_x);
               if (rsp_data.dir_y !== want.dir_y) report("dir_y", rsp_data.dir_y, want.dir_y);
               if (rsp_data.dir_z !== want.dir_z) report("dir_z", rsp_data.dir_z, want.dir_z);
            end
         end
      end
   end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Top of the fly-camera testbench: clock, reset, stimulus and verdict.
// Depends on ecam_pkg, euler_fly_camera_update and ecam_checker.
module tb;
   import ecam_pkg::*;

   localparam logic [CSR_IW-1:0] CSR_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 4000000;

   logic    clock, reset;
   logic    req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   req_type req_data;
   rsp_type rsp_data;
   logic [CSR_IW-1:0] csr_index;
   logic [15:0] csr_data;
   int      fail_count, pending;
   bit      hold_req, hold_done;
   int      burst_left, mouse_beats, tick_beats, settings;
   int      cycles;

   euler_fly_camera_update u_dut (.*);

   ecam_checker u_check (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Every input starts at a known value.
   initial begin
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_valid = 0;
      csr_index = CSR_MOUSE_ENABLE;
      csr_data = '0;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Receiver: segments of free flow and stall patterns, plus one long hold-off.
   initial begin
      int seg, style;
      rsp_ready = 0;
      hold_done = 0;
      forever begin
         if (hold_req && !hold_done) begin
            rsp_ready <= 0;
            repeat (2500) @(posedge clock);
            hold_done = 1;
         end else begin
            seg = $urandom_range(8, 64);
            style = $urandom_range(0, 2);
            for (int k = 0; k < seg; k++) begin
               rsp_ready <= style == 0 ? 1'b1 : style == 1 ? (k % 3 != 0) : 1'($urandom);
               @(posedge clock);
            end
         end
      end
   end

   task automatic reg_write(input logic [CSR_IW-1:0] idx, input logic [15:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Writes a full register setting; the block must be idle.
   task automatic load_setting(input bit on, input logic [15:0] gain,
                               input int ux, input int uy, input int uz);
      reg_write(CSR_MOUSE_ENABLE, 16'(on));
      reg_write(CSR_MOUSE_GAIN, gain);
      reg_write(CSR_UP_X, 16'(ux));
      reg_write(CSR_UP_Y, 16'(uy));
      reg_write(CSR_UP_Z, 16'(uz));
      csr_valid <= 0;
      @(posedge clock);
      settings++;
   endtask

   // Offers one beat, inserting a random gap between bursts.
   task automatic offer(input req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 15);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      if (item.func == FUNC_MOUSE) mouse_beats++;
      else tick_beats++;
   endtask

   // First waits on the clock, so that the beat just accepted is already counted.
   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   function automatic req_type mouse_beat(input logic [15:0] dx, input logic [15:0] dy);
      req_type r;
      r = '0;
      r.func = FUNC_MOUSE;
      r.mouse_dx = dx;
      r.mouse_dy = dy;
      r.tick_seconds = 16'($urandom);
      return r;
   endfunction

   function automatic req_type tick_beat(input logic [15:0] dt, input logic [5:0] keys);
      req_type r;
      r = '0;
      r.func = FUNC_TICK;
      r.mouse_dx = 16'($urandom);
      r.mouse_dy = 16'($urandom);
      r.tick_seconds = dt;
      {r.key_forward, r.key_back, r.key_left, r.key_right, r.key_rise, r.key_sink} = keys;
      return r;
   endfunction

   function automatic req_type random_beat;
      logic [15:0] dx, dy;
      if ($urandom_range(0, 99) < 45) begin
         if ($urandom_range(0, 3) == 0) begin
            dx = 16'($urandom);
            dy = 16'($urandom);
         end else begin
            dx = 16'($urandom_range(0, 4095) - 2048);
            dy = 16'($urandom_range(0, 4095) - 2048);
         end
         return mouse_beat(dx, dy);
      end
      return tick_beat(16'($urandom), 6'($urandom));
   endfunction

   function automatic int up_part;
      return $urandom_range(0, 32768) - 16384;
   endfunction

   initial begin
      hold_req = 0;
      burst_left = 0;
      mouse_beats = 0;
      tick_beats = 0;
      settings = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Reset values, then a write to an index past the register list.
      load_setting(1, 16'd6554, 0, 16384, 0);
      reg_write(CSR_UNUSED, 16'hFFFF);
      csr_valid <= 0;
      @(posedge clock);

      // Directed: motion from the reset look, extreme offsets, yaw wrap, pitch clamp.
      offer(tick_beat(16'hFFFF, 6'b111111));
      offer(tick_beat(16'd0, 6'b111111));
      offer(tick_beat(16'hFFFF, 6'b100000));
      offer(tick_beat(16'hFFFF, 6'b010000));
      offer(tick_beat(16'd1, 6'b001100));
      offer(mouse_beat(16'd0, 16'd0));
      drain();
      load_setting(1, 16'hFFFF, 0, 16384, 0);
      offer(mouse_beat(16'h7FFF, 16'h7FFF));
      offer(mouse_beat(16'h7FFF, 16'h7FFF));
      offer(mouse_beat(16'h8000, 16'h8000));
      offer(mouse_beat(16'h8000, 16'h8000));
      offer(mouse_beat(16'h8000, 16'h0000));
      offer(tick_beat(16'hFFFF, 6'b001000));
      offer(tick_beat(16'hFFFF, 6'b000100));
      offer(tick_beat(16'h8000, 6'b000011));
      drain();
      // Up vector zero: no side axis and no vertical motion.
      load_setting(0, 16'd0, 0, 0, 0);
      offer(mouse_beat(16'h1234, 16'h0F00));
      offer(tick_beat(16'hFFFF, 6'b111111));
      offer(tick_beat(16'hFFFF, 6'b001100));
      drain();

      // Random phases over several register settings.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: load_setting(1, 16'd6554, 0, 16384, 0);
            1: load_setting(1, 16'hFFFF, 16384, 16384, 16384);
            2: load_setting(0, 16'($urandom), -16384, -16384, -16384);
            3: load_setting(1, 16'd0, 0, 0, 0);
            4: load_setting(1, 16'($urandom), up_part(), up_part(), up_part());
            default: load_setting(1, 16'($urandom_range(1000, 20000)), 0, 16384, 0);
         endcase
         if (ph == 1) hold_req = 1;
         for (int n = 0; n < 205; n++) offer(random_beat());
         drain();
      end

      repeat (400) @(posedge clock);
      $display("Covered %0d mouse and %0d tick beats over %0d register settings,",
               mouse_beats, tick_beats, settings);
      $display("with bursty input, stalled output and one long output hold-off.");
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
